// ===== hw/rtl/handle_slot_registry_core_macros.svh =====
// ----------------------------------------------------------------------------
// handle_slot_registry_core_macros
// Assertion macros shared by the slot registry RTL.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_REGISTRY_CORE_MACROS_SVH
`define HANDLE_SLOT_REGISTRY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot registry check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot registry check failed");

`endif

// ===== hw/rtl/hsr_pkg.sv =====
// ----------------------------------------------------------------------------
// hsr_pkg
// Types and operation codes of the handle slot registry.
// ----------------------------------------------------------------------------
package hsr_pkg;

	localparam logic [2:0] OP_REGISTER     = 3'd0;
	localparam logic [2:0] OP_REMOVE_KEY   = 3'd1;
	localparam logic [2:0] OP_REMOVE_GROUP = 3'd2;
	localparam logic [2:0] OP_COUNT_GROUP  = 3'd3;
	localparam logic [2:0] OP_NTH          = 3'd4;
	localparam logic [2:0] OP_LOOKUP       = 3'd5;

	typedef struct packed {
		logic [2:0]         operation;
		logic [31:0]        item_key;
		logic [31:0]        group_tag;
		logic signed [15:0] kind_code;
		logic signed [15:0] position;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [31:0]        found_key;
		logic signed [15:0] found_kind;
		logic [8:0]         group_count;
		logic [31:0]        generation_now;
		logic               table_complete;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_COMMIT,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/hsr_chan_if.sv =====
// ----------------------------------------------------------------------------
// hsr_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface hsr_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hsr_ram.sv =====
// ----------------------------------------------------------------------------
// hsr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hsr_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/handle_slot_registry_core.sv =====
// ----------------------------------------------------------------------------
// handle_slot_registry_core
// Slot table of keys with group tags and kinds, scanned from one RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req (operation, key, group, kind, position) and each one
// produces exactly one item on rsp. Every operation walks the whole slot RAM
// once, one slot per cycle through its single read port; removals write the
// freed slot back as it passes, a register writes its slot after the walk.
// A new request is therefore taken only after the previous one has finished
// its walk and loaded its response into the output register.
// After reset the block sweeps the RAM to zero, one slot per cycle, and
// req.ready stays low during that sweep.
// The response sits in an output register. A new request is accepted while
// an earlier response waits; if rsp is still stalled when the next response
// is ready, the block holds in its final state until the register frees up.
// ----------------------------------------------------------------------------
`include "handle_slot_registry_core_macros.svh"

module handle_slot_registry_core #(
	parameter int SLOT_COUNT = 256,
	parameter int KEY_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	hsr_chan_if.sink    req,
	hsr_chan_if.source  rsp
);
	import hsr_pkg::*;

	localparam int KW     = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int AW     = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int WORD_W = KW + 32 + 16;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	logic [AW-1:0]     cnt_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     idx_s1;

	// Request held for the duration of one walk.
	logic [2:0]        op_q;
	logic              en_q;
	logic [KW-1:0]     key_q;
	logic [31:0]       grp_q;
	logic [15:0]       kind_q;
	logic [15:0]       pos_q;

	logic              hit_q, free_q, found_q;
	logic [AW-1:0]     hit_idx_q, free_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [KW-1:0]     fkey_q;
	logic [15:0]       fkind_q;
	logic [31:0]       gen_q;
	logic              complete_q;

	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              en_d;
	logic              key_nz, grp_nz;
	logic              rsp_load;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic [KW-1:0]     key_d;
	logic [31:0]       grp_d;
	logic [15:0]       kind_d;
	logic              live, key_match, grp_match;
	logic              reg_place, is_change;

	hsr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign accept  = req.valid && req.ready;
	assign key_nz  = |req.data.item_key[KW-1:0];
	assign grp_nz  = |req.data.group_tag;

	// An operation with a zero key or group, a negative nth position, or an unused code, does nothing.
	always_comb begin
		unique case (req.data.operation)
			OP_REGISTER, OP_REMOVE_KEY, OP_LOOKUP: en_d = key_nz;
			OP_REMOVE_GROUP, OP_COUNT_GROUP:       en_d = grp_nz;
			OP_NTH:  en_d = grp_nz && !req.data.position[15];
			default: en_d = 1'b0;
		endcase
	end

	assign {key_d, grp_d, kind_d} = ram_rdata;
	assign live      = |key_d;
	assign key_match = (key_d == key_q);
	assign grp_match = (grp_d == grp_q);
	assign reg_place = en_q && (op_q == OP_REGISTER) && (hit_q || free_q);
	assign is_change = en_q && ((op_q == OP_REGISTER) || (op_q == OP_REMOVE_KEY) ||
		(op_q == OP_REMOVE_GROUP));
	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (cnt_q == LAST_SLOT) state_d = ST_IDLE;
			ST_IDLE:   if (req.valid) state_d = ST_SCAN;
			ST_SCAN:   if (cnt_q == LAST_SLOT) state_d = ST_TAIL;
			ST_TAIL:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_FINISH;
			ST_FINISH: if (rsp_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and RAM port controls.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR:  ram_we = 1'b1;
			ST_SCAN:   ram_re = 1'b1;
			ST_COMMIT: begin
				if (reg_place) begin
					ram_we    = 1'b1;
					ram_waddr = hit_q ? hit_idx_q : free_idx_q;
					ram_wdata = {key_q, grp_q, kind_q};
				end
			end
			default: ;
		endcase
		// A removal frees the slot whose data just came back from the RAM.
		if (rd_valid_s1 && en_q &&
			(((op_q == OP_REMOVE_KEY) && key_match) ||
			((op_q == OP_REMOVE_GROUP) && grp_match))) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				cnt_q <= '0;
			end else if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			op_q   <= req.data.operation;
			en_q   <= en_d;
			key_q  <= req.data.item_key[KW-1:0];
			grp_q  <= req.data.group_tag;
			kind_q <= req.data.kind_code;
			pos_q  <= req.data.position;
		end
	end

	// Scan results, gathered slot by slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			found_q    <= 1'b0;
			count_q    <= '0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			fkey_q     <= '0;
			fkind_q    <= '0;
		end else if (accept) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			found_q <= 1'b0;
			count_q <= '0;
			fkey_q  <= '0;
			fkind_q <= '0;
		end else if (rd_valid_s1 && en_q) begin
			unique case (op_q)
				OP_REGISTER: begin
					if (key_match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (!live && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
				end
				OP_COUNT_GROUP: begin
					if (live && grp_match) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_NTH: begin
					// The running count is the index of this entry in its group.
					if (live && grp_match) begin
						if (!found_q && (16'(count_q) == pos_q)) begin
							found_q <= 1'b1;
							fkey_q  <= key_d;
						end
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_LOOKUP: begin
					if (key_match && !found_q) begin
						found_q <= 1'b1;
						fkind_q <= kind_d;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= '0;
			complete_q <= 1'b1;
		end else if (state_q == ST_COMMIT) begin
			if (is_change) begin
				gen_q <= gen_q + 32'd1;
			end
			if (en_q && (op_q == OP_REGISTER) && !hit_q && !free_q) begin
				complete_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.found          <= found_q;
			rsp_q.found_key      <= 32'(fkey_q);
			rsp_q.found_kind     <= fkind_q;
			rsp_q.group_count    <= (op_q == OP_COUNT_GROUP) ? 9'(count_q) : 9'd0;
			rsp_q.generation_now <= gen_q;
			rsp_q.table_complete <= complete_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// A write-back during the walk never hits the slot being read.
	`HSR_ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != cnt_q)
	// The change count moves only when an item commits.
	`HSR_ASSERT_IMP(a_gen_at_commit, clk, arst_n, gen_q != $past(gen_q),
		$past(state_q) == ST_COMMIT)
	// Once an entry has been dropped the table never reports complete again.
	`HSR_ASSERT_IMP(a_complete_sticky, clk, arst_n, !$past(complete_q), !complete_q)
	// A new response is only loaded from the final state.
	`HSR_ASSERT_IMP(a_rsp_from_finish, clk, arst_n, $rose(rsp_valid_q),
		$past(state_q) == ST_FINISH)
	// No request is taken while the reset sweep is running.
	`HSR_ASSERT_NXT(a_clear_blocks, clk, arst_n, state_q == ST_CLEAR && cnt_q != LAST_SLOT,
		state_q == ST_CLEAR)

endmodule

// ===== tb/handle_slot_registry_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_slot_registry_core_tb
// Self-checking bench for the slot registry: requests are predicted against
// a private copy of the slot table and every reply is compared field by field.
// ----------------------------------------------------------------------------
module handle_slot_registry_core_tb;
	import hsr_pkg::*;

	localparam int SLOTS           = 256;
	localparam int CLK_PERIOD      = 10;
	localparam int CYCLE_LIMIT     = 5_000_000;
	localparam int HOLDOFF_AFTER   = 200;
	localparam int HOLDOFF_CYCLES  = 3000;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [31:0] FILL_GROUP = 32'hC0DE_0007;
	localparam logic [31:0] FILL_BASE  = 32'h4000_0000;
	localparam int FILL_ITEMS      = 280;

	// Private model of the slot table and the expected replies.
	class slot_registry_scoreboard;
		logic [31:0]        keys_held [SLOTS];
		logic [31:0]        groups_held [SLOTS];
		logic signed [15:0] kinds_held [SLOTS];
		logic [31:0]        generation;
		logic               whole;
		rsp_t               awaited_replies [$];
		int                 failures;
		int                 op_seen [8];
		int                 dropped;
		int                 hits;
		int                 widest_count;

		function new();
			foreach (keys_held[i]) begin
				keys_held[i] = '0;
				groups_held[i] = '0;
				kinds_held[i] = '0;
			end
			generation = '0;
			whole = 1'b1;
			failures = 0;
			dropped = 0;
			hits = 0;
			widest_count = 0;
			foreach (op_seen[i])
				op_seen[i] = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			bit          done;
			int unsigned n;
			int unsigned count;
			e = '0;
			count = 0;
			op_seen[r.operation]++;
			case (r.operation)
				OP_REGISTER: begin
					if (r.item_key != '0) begin
						generation++;
						done = 1'b0;
						for (int i = 0; i < SLOTS && !done; i++) begin
							if (keys_held[i] == r.item_key) begin
								groups_held[i] = r.group_tag;
								kinds_held[i] = r.kind_code;
								done = 1'b1;
							end
						end
						for (int i = 0; i < SLOTS && !done; i++) begin
							if (keys_held[i] == '0) begin
								keys_held[i] = r.item_key;
								groups_held[i] = r.group_tag;
								kinds_held[i] = r.kind_code;
								done = 1'b1;
							end
						end
						if (!done) begin
							whole = 1'b0;
							dropped++;
						end
					end
				end
				OP_REMOVE_KEY: begin
					if (r.item_key != '0) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (keys_held[i] == r.item_key) begin
								keys_held[i] = '0;
								groups_held[i] = '0;
								kinds_held[i] = '0;
							end
						end
						generation++;
					end
				end
				OP_REMOVE_GROUP: begin
					if (r.group_tag != '0) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (groups_held[i] == r.group_tag) begin
								keys_held[i] = '0;
								groups_held[i] = '0;
								kinds_held[i] = '0;
							end
						end
						generation++;
					end
				end
				OP_COUNT_GROUP: begin
					if (r.group_tag != '0) begin
						for (int i = 0; i < SLOTS; i++)
							if (keys_held[i] != '0 && groups_held[i] == r.group_tag)
								count++;
					end
					if (count > widest_count)
						widest_count = count;
				end
				OP_NTH: begin
					if (r.group_tag != '0 && !r.position[15]) begin
						n = 0;
						for (int i = 0; i < SLOTS && !e.found; i++) begin
							if (keys_held[i] != '0 && groups_held[i] == r.group_tag) begin
								if (n == r.position) begin
									e.found = 1'b1;
									e.found_key = keys_held[i];
								end
								n++;
							end
						end
					end
				end
				OP_LOOKUP: begin
					if (r.item_key != '0) begin
						for (int i = 0; i < SLOTS && !e.found; i++) begin
							if (keys_held[i] == r.item_key) begin
								e.found = 1'b1;
								e.found_kind = kinds_held[i];
							end
						end
					end
				end
				default: ;
			endcase
			if (e.found)
				hits++;
			e.group_count = count[8:0];
			e.generation_now = generation;
			e.table_complete = whole;
			awaited_replies.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				failures++;
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited_replies.size() == 0) begin
				failures++;
				$error("reply item arrived with no request outstanding");
				return;
			end
			want = awaited_replies.pop_front();
			compare_field("found", 32'(want.found), 32'(got.found));
			compare_field("found_key", want.found_key, got.found_key);
			compare_field("found_kind", 32'(want.found_kind), 32'(got.found_kind));
			compare_field("group_count", 32'(want.group_count), 32'(got.group_count));
			compare_field("generation_now", want.generation_now, got.generation_now);
			compare_field("table_complete", 32'(want.table_complete),
				32'(got.table_complete));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	hsr_chan_if #(.payload_t(req_t)) req ();
	hsr_chan_if #(.payload_t(rsp_t)) rsp ();

	handle_slot_registry_core #(
		.SLOT_COUNT(SLOTS),
		.KEY_BITS  (32)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	slot_registry_scoreboard sb;
	int          cycle_count = 0;
	int          replies_seen = 0;
	int          burst_left = 0;
	int          seg_left = 0;
	int          holdoff_left = 0;
	bit          holdoff_done = 1'b0;
	logic [15:0] ready_mask = '1;
	logic [3:0]  tick = '0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Reply side: segments of free flow, random stalls and full stops, plus
	// one long hold-off that backs the block up into its request port.
	always @(posedge clk) begin
		tick <= tick + 1'b1;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			rsp.ready <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && replies_seen >= HOLDOFF_AFTER) begin
			holdoff_done <= 1'b1;
			holdoff_left <= HOLDOFF_CYCLES;
			rsp.ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left <= $urandom_range(16, 600);
				case ($urandom_range(0, 3))
					0: ready_mask <= 16'($urandom);
					1: ready_mask <= '0;
					default: ready_mask <= '1;
				endcase
			end else begin
				seg_left <= seg_left - 1;
			end
			rsp.ready <= ready_mask[tick];
		end
	end

	// The reply channel is observed at the falling edge ahead of the accepting edge.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			sb.check_response(rsp.data);
			replies_seen++;
		end
	end

	function automatic req_t make_request(logic [2:0] op, logic [31:0] key, logic [31:0] grp,
			logic [15:0] kind, logic [15:0] pos);
		req_t r;
		r.operation = op;
		r.item_key = key;
		r.group_tag = grp;
		r.kind_code = kind;
		r.position = pos;
		return r;
	endfunction

	function automatic req_t random_request(int unsigned key_span);
		req_t        r;
		int unsigned w;
		case ($urandom_range(0, 19))
			0: r.item_key = '0;
			1: r.item_key = $urandom;
			2: r.item_key = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: r.item_key = $urandom_range(1, key_span);
		endcase
		case ($urandom_range(0, 19))
			0: r.group_tag = '0;
			1: r.group_tag = $urandom;
			2: r.group_tag = FILL_GROUP;
			3: r.group_tag = 32'hFFFF_FFFF;
			default: r.group_tag = $urandom_range(1, 6);
		endcase
		r.kind_code = 16'($urandom);
		case ($urandom_range(0, 9))
			0: r.position = 16'($urandom);
			1: r.position = {1'b1, 15'($urandom)};
			default: r.position = 16'($urandom_range(0, 10));
		endcase
		w = $urandom_range(0, 99);
		if (w < 35)
			r.operation = OP_REGISTER;
		else if (w < 45)
			r.operation = OP_REMOVE_KEY;
		else if (w < 50)
			r.operation = OP_REMOVE_GROUP;
		else if (w < 65)
			r.operation = OP_COUNT_GROUP;
		else if (w < 80)
			r.operation = OP_NTH;
		else if (w < 97)
			r.operation = OP_LOOKUP;
		else if (w < 99)
			r.operation = OP_SPARE_LO;
		else
			r.operation = OP_SPARE_HI;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge that accepted the item.
	task automatic offer_request(input req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			req.valid <= 1'b0;
			case ($urandom_range(0, 2))
				0: repeat ($urandom_range(1, 20)) @(posedge clk);
				1: repeat ($urandom_range(230, 300)) @(posedge clk);
				default: repeat ($urandom_range(1, 600)) @(posedge clk);
			endcase
		end
		burst_left--;
		req.data <= r;
		req.valid <= 1'b1;
		do
			@(negedge clk);
		while (req.ready !== 1'b1);
		@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic wait_for_replies();
		req.valid <= 1'b0;
		while (sb.awaited_replies.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, updates in place, every operation and the
		// zero-key, zero-group, negative-position and spare-code cases.
		offer_request(make_request(OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'd1, 32'd0, 16'h7FFF, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'd0, 32'd5, 16'd1, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'd2, 32'hFFFF_FFFF, 16'hFFFF, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'd1, 32'd3, 16'd100, 16'h0));
		offer_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_LOOKUP, 32'd1, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_LOOKUP, 32'd0, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_LOOKUP, 32'd12345, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_COUNT_GROUP, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h0));
		offer_request(make_request(OP_COUNT_GROUP, 32'd0, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_NTH, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h0));
		offer_request(make_request(OP_NTH, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h1));
		offer_request(make_request(OP_NTH, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h2));
		offer_request(make_request(OP_NTH, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF));
		offer_request(make_request(OP_NTH, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h7FFF));
		offer_request(make_request(OP_NTH, 32'd1, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_SPARE_LO, 32'd1, 32'd3, 16'h1, 16'h0));
		offer_request(make_request(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		offer_request(make_request(OP_REMOVE_KEY, 32'd0, 32'd3, 16'h0, 16'h0));
		offer_request(make_request(OP_REMOVE_KEY, 32'd1, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'd3, 32'd3, 16'd7, 16'h0));
		offer_request(make_request(OP_NTH, 32'd0, 32'd3, 16'h0, 16'h0));
		offer_request(make_request(OP_REMOVE_GROUP, 32'd2, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_REMOVE_GROUP, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h0));
		offer_request(make_request(OP_COUNT_GROUP, 32'd0, 32'hFFFF_FFFF, 16'h0, 16'h0));

		// Small key pool so that updates, removals and group queries collide.
		repeat (500)
			offer_request(random_request(48));

		// Fill the table past its capacity from a drained block.
		wait_for_replies();
		for (int i = 0; i < FILL_ITEMS; i++)
			offer_request(make_request(OP_REGISTER, FILL_BASE + i, FILL_GROUP, 16'(i), 16'h0));
		offer_request(make_request(OP_COUNT_GROUP, 32'd0, FILL_GROUP, 16'h0, 16'h0));
		offer_request(make_request(OP_NTH, 32'd0, FILL_GROUP, 16'h0, 16'd200));
		offer_request(make_request(OP_LOOKUP, FILL_BASE + FILL_ITEMS - 1, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_REGISTER, FILL_BASE, 32'd2, 16'hFFFB, 16'h0));
		offer_request(make_request(OP_LOOKUP, FILL_BASE, 32'd0, 16'h0, 16'h0));
		offer_request(make_request(OP_REMOVE_GROUP, 32'd0, FILL_GROUP, 16'h0, 16'h0));
		offer_request(make_request(OP_REGISTER, 32'h7777_0001, 32'd1, 16'd9, 16'h0));
		offer_request(make_request(OP_COUNT_GROUP, 32'd0, 32'd1, 16'h0, 16'h0));

		// Wider key pool against the table left after the fill.
		wait_for_replies();
		repeat (300)
			offer_request(random_request(400));

		wait_for_replies();
		repeat (2 * (SLOTS + 4)) @(posedge clk);
		if (sb.awaited_replies.size() != 0) begin
			sb.failures++;
			$error("%0d reply items never arrived", sb.awaited_replies.size());
		end

		$display("Covered %0d registers (%0d dropped on a full table), %0d key and %0d group removes,",
			sb.op_seen[OP_REGISTER], sb.dropped, sb.op_seen[OP_REMOVE_KEY],
			sb.op_seen[OP_REMOVE_GROUP]);
		$display("%0d counts (largest %0d), %0d nth, %0d lookups, %0d hits, %0d spare codes.",
			sb.op_seen[OP_COUNT_GROUP], sb.widest_count, sb.op_seen[OP_NTH],
			sb.op_seen[OP_LOOKUP], sb.hits, sb.op_seen[OP_SPARE_LO] + sb.op_seen[OP_SPARE_HI]);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hsr_pkg.sv
hw/rtl/hsr_chan_if.sv
hw/rtl/hsr_ram.sv
hw/rtl/handle_slot_registry_core.sv
tb/handle_slot_registry_core_tb.sv
